// ===== rtl/touch_gesture_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Touch gesture classifier assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define TGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TGC_ASSERT_NEVER(lbl, cond, msg) \
  `TGC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned TimeBits  = 32;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxTapDist  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxTapTime  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxSwipeTime = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxHoldTime = 3'd3;

  // register reset values
  localparam logic [CfgW-1:0] TapDistRst   = 16'd3277;  // ~0.05 of screen
  localparam logic [CfgW-1:0] TapTimeRst   = 16'd300;
  localparam logic [CfgW-1:0] SwipeTimeRst = 16'd500;
  localparam logic [CfgW-1:0] HoldTimeRst  = 16'd500;

  typedef enum logic [1:0] {
    FUNC_DOWN   = 2'd0,
    FUNC_MOTION = 2'd1,
    FUNC_UP     = 2'd2,
    FUNC_TICK   = 2'd3
  } tgc_func_e;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_TAP   = 3'd1,
    GEST_LONG  = 3'd2,
    GEST_UP    = 3'd3,
    GEST_DOWN  = 3'd4,
    GEST_LEFT  = 3'd5,
    GEST_RIGHT = 3'd6
  } tgc_gesture_e;

  typedef struct packed {
    logic [CfgW-1:0] tap_radius;
    logic [CfgW-1:0] tap_limit_ms;
    logic [CfgW-1:0] swipe_limit_ms;
    logic [CfgW-1:0] hold_limit_ms;
  } tgc_cfg_t;

endpackage

// ===== rtl/tgc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tgc_cfg_regs
// Configuration register file, one write beat per cycle.
// ----------------------------------------------------------------------------
module tgc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [tgc_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [tgc_pkg::CfgW-1:0]      wr_data_i,
  output tgc_pkg::tgc_cfg_t             cfg_o
);

  tgc_pkg::tgc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        tgc_pkg::CfgIdxTapDist:   cfg_d.tap_radius     = wr_data_i;
        tgc_pkg::CfgIdxTapTime:   cfg_d.tap_limit_ms   = wr_data_i;
        tgc_pkg::CfgIdxSwipeTime: cfg_d.swipe_limit_ms = wr_data_i;
        tgc_pkg::CfgIdxHoldTime:  cfg_d.hold_limit_ms  = wr_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_radius     <= tgc_pkg::TapDistRst;
      cfg_q.tap_limit_ms   <= tgc_pkg::TapTimeRst;
      cfg_q.swipe_limit_ms <= tgc_pkg::SwipeTimeRst;
      cfg_q.hold_limit_ms  <= tgc_pkg::HoldTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tgc_classify.sv =====
// ----------------------------------------------------------------------------
// tgc_classify
// Single-pass event evaluation: next touch state and the gesture code.
// ----------------------------------------------------------------------------
module tgc_classify #(
  parameter int unsigned COORD_BITS = tgc_pkg::CoordBits,
  parameter int unsigned TIME_BITS  = tgc_pkg::TimeBits
) (
  input  tgc_pkg::tgc_cfg_t         cfg_i,
  input  logic [1:0]                func_i,
  input  logic [COORD_BITS-1:0]     x_i,
  input  logic [COORD_BITS-1:0]     y_i,
  input  logic [TIME_BITS-1:0]      now_i,
  // current state
  input  logic                      touching_i,
  input  logic                      hold_i,
  input  logic [COORD_BITS-1:0]     origin_x_i,
  input  logic [COORD_BITS-1:0]     origin_y_i,
  input  logic [COORD_BITS-1:0]     recent_x_i,
  input  logic [COORD_BITS-1:0]     recent_y_i,
  input  logic [TIME_BITS-1:0]      press_time_i,
  input  logic [TIME_BITS-1:0]      recent_time_i,
  // next state
  output logic                      touching_o,
  output logic                      hold_o,
  output logic [COORD_BITS-1:0]     origin_x_o,
  output logic [COORD_BITS-1:0]     origin_y_o,
  output logic [COORD_BITS-1:0]     recent_x_o,
  output logic [COORD_BITS-1:0]     recent_y_o,
  output logic [TIME_BITS-1:0]      press_time_o,
  output logic [TIME_BITS-1:0]      recent_time_o,
  output tgc_pkg::tgc_gesture_e     gesture_o
);

  localparam int unsigned SqW   = 2 * COORD_BITS;
  localparam int unsigned SumW  = (SqW + 1 > 2 * tgc_pkg::CfgW) ? SqW + 1 : 2 * tgc_pkg::CfgW;
  localparam int unsigned CmpW  = (COORD_BITS > tgc_pkg::CfgW) ? COORD_BITS : tgc_pkg::CfgW;

  tgc_pkg::tgc_func_e func;
  logic                  is_motion;
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic signed [COORD_BITS:0] dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay;
  logic [SqW-1:0]        ax_sq, ay_sq;
  logic [2*tgc_pkg::CfgW-1:0] td_sq;
  logic [SumW-1:0]       dist_sq;
  logic                  near_origin;
  logic [TIME_BITS-1:0]  hold_el, dur;
  logic                  hold_fire;
  logic                  in_box;
  tgc_pkg::tgc_gesture_e up_gest;

  assign func      = tgc_pkg::tgc_func_e'(func_i);
  assign is_motion = (func == tgc_pkg::FUNC_MOTION);

  // a motion beat is tested at its own position
  assign cur_x = is_motion ? x_i : recent_x_i;
  assign cur_y = is_motion ? y_i : recent_y_i;

  assign dx     = $signed({1'b0, cur_x}) - $signed({1'b0, origin_x_i});
  assign dy     = $signed({1'b0, cur_y}) - $signed({1'b0, origin_y_i});
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax     = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay     = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

  assign ax_sq   = SqW'(ax) * SqW'(ax);
  assign ay_sq   = SqW'(ay) * SqW'(ay);
  assign td_sq   = (2*tgc_pkg::CfgW)'(cfg_i.tap_radius) *
                   (2*tgc_pkg::CfgW)'(cfg_i.tap_radius);
  assign dist_sq = SumW'(ax_sq) + SumW'(ay_sq);
  assign near_origin = dist_sq < SumW'(td_sq);

  // wrapping time differences
  assign hold_el = now_i - press_time_i;
  assign dur     = recent_time_i - press_time_i;

  assign hold_fire = touching_i && !hold_i && near_origin &&
                     (32'(hold_el) > 32'(cfg_i.hold_limit_ms));

  assign in_box = (CmpW'(ax) < CmpW'(cfg_i.tap_radius)) &&
                  (CmpW'(ay) < CmpW'(cfg_i.tap_radius));

  always_comb begin
    if (in_box) begin
      up_gest = (32'(dur) < 32'(cfg_i.tap_limit_ms)) ? tgc_pkg::GEST_TAP
                                                     : tgc_pkg::GEST_NONE;
    end else if (32'(dur) >= 32'(cfg_i.swipe_limit_ms)) begin
      up_gest = tgc_pkg::GEST_NONE;
    end else if (ax > ay) begin
      up_gest = (!dx[COORD_BITS] && (dx != '0)) ? tgc_pkg::GEST_RIGHT
                                                : tgc_pkg::GEST_LEFT;
    end else begin
      up_gest = dy[COORD_BITS] ? tgc_pkg::GEST_UP : tgc_pkg::GEST_DOWN;
    end
  end

  always_comb begin
    touching_o    = touching_i;
    hold_o        = hold_i;
    origin_x_o    = origin_x_i;
    origin_y_o    = origin_y_i;
    recent_x_o    = recent_x_i;
    recent_y_o    = recent_y_i;
    press_time_o  = press_time_i;
    recent_time_o = recent_time_i;
    gesture_o     = tgc_pkg::GEST_NONE;
    unique case (func)
      tgc_pkg::FUNC_DOWN: begin
        touching_o    = 1'b1;
        hold_o        = 1'b0;
        origin_x_o    = x_i;
        origin_y_o    = y_i;
        recent_x_o    = x_i;
        recent_y_o    = y_i;
        press_time_o  = now_i;
        recent_time_o = now_i;
      end
      tgc_pkg::FUNC_MOTION: begin
        if (touching_i) begin
          recent_x_o    = x_i;
          recent_y_o    = y_i;
          recent_time_o = now_i;
        end
        if (hold_fire) begin
          hold_o    = 1'b1;
          gesture_o = tgc_pkg::GEST_LONG;
        end
      end
      tgc_pkg::FUNC_UP: begin
        if (touching_i) begin
          touching_o = 1'b0;
          if (!hold_i) gesture_o = up_gest;
        end
      end
      tgc_pkg::FUNC_TICK: begin
        if (hold_fire) begin
          hold_o    = 1'b1;
          gesture_o = tgc_pkg::GEST_LONG;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/touch_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Tap / long-press / four-way swipe detector over a stream of touch events.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   event in | in_valid_i / in_ready_o | func_i, touch_x_i, touch_y_i, now_ms_i
//   result   | out_valid_o/ out_ready_i| gesture_o
//   config   | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_value_i
//
// One event per clock sustained while the result channel is not stalled; a
// result passes through the input register, then the result register.
// The touch state feedback (squares, compare, state update) is combinational
// between the input register and the result register.
// A stalled result register holds the input register, which then holds the
// event channel; config is always ready.
// Async active-low reset: not touching, config at default values.
// ----------------------------------------------------------------------------
`include "touch_gesture_classifier_assert.svh"

module touch_gesture_classifier #(
  parameter int unsigned COORD_BITS = tgc_pkg::CoordBits,
  parameter int unsigned TIME_BITS  = tgc_pkg::TimeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [COORD_BITS-1:0]         touch_x_i,
  input  logic [COORD_BITS-1:0]         touch_y_i,
  input  logic [TIME_BITS-1:0]          now_ms_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    gesture_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgc_pkg::CfgW-1:0]      cfg_value_i
);

  tgc_pkg::tgc_cfg_t cfg;

  // input register
  logic                  in_valid_q;
  logic [1:0]            func_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [TIME_BITS-1:0]  now_q;

  // touch state
  logic                  touching_q, touching_d;
  logic                  hold_q, hold_d;
  logic [COORD_BITS-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [COORD_BITS-1:0] recent_x_q, recent_x_d, recent_y_q, recent_y_d;
  logic [TIME_BITS-1:0]  press_time_q, press_time_d;
  logic [TIME_BITS-1:0]  recent_time_q, recent_time_d;

  // result register
  logic                  out_valid_q;
  tgc_pkg::tgc_gesture_e gesture_q, gesture_d;

  logic advance;  // result register free to take the staged beat
  logic process;  // staged beat evaluated this cycle

  assign cfg_ready_o = 1'b1;

  tgc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_value_i),
    .cfg_o     (cfg)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  tgc_classify #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_classify (
    .cfg_i         (cfg),
    .func_i        (func_q),
    .x_i           (x_q),
    .y_i           (y_q),
    .now_i         (now_q),
    .touching_i    (touching_q),
    .hold_i        (hold_q),
    .origin_x_i    (origin_x_q),
    .origin_y_i    (origin_y_q),
    .recent_x_i    (recent_x_q),
    .recent_y_i    (recent_y_q),
    .press_time_i  (press_time_q),
    .recent_time_i (recent_time_q),
    .touching_o    (touching_d),
    .hold_o        (hold_d),
    .origin_x_o    (origin_x_d),
    .origin_y_o    (origin_y_d),
    .recent_x_o    (recent_x_d),
    .recent_y_o    (recent_y_d),
    .press_time_o  (press_time_d),
    .recent_time_o (recent_time_d),
    .gesture_o     (gesture_d)
  );

  // input register: takes a beat when empty or whenever the staged one moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q <= func_i;
      x_q    <= touch_x_i;
      y_q    <= touch_y_i;
      now_q  <= now_ms_i;
    end
  end

  // touch state, updated once per evaluated beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q    <= 1'b0;
      hold_q        <= 1'b0;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      recent_x_q    <= '0;
      recent_y_q    <= '0;
      press_time_q  <= '0;
      recent_time_q <= '0;
    end else if (process) begin
      touching_q    <= touching_d;
      hold_q        <= hold_d;
      origin_x_q    <= origin_x_d;
      origin_y_q    <= origin_y_d;
      recent_x_q    <= recent_x_d;
      recent_y_q    <= recent_y_d;
      press_time_q  <= press_time_d;
      recent_time_q <= recent_time_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

  // every evaluated beat lands in the result register
  `TGC_ASSERT(a_process_fills_result, process |=> out_valid_q,
              "evaluated beat did not reach the result register")

  // long press flag only sets together with a long-press result
  `TGC_ASSERT(a_hold_with_long, $rose(hold_q) |-> (out_valid_q &&
              (gesture_q == tgc_pkg::GEST_LONG)),
              "long-press flag set without a long-press result")

  // tap and swipe results end the touch
  `TGC_ASSERT_NEVER(a_tap_swipe_ends_touch, process &&
                    (gesture_d != tgc_pkg::GEST_NONE) &&
                    (gesture_d != tgc_pkg::GEST_LONG) && touching_d,
                    "tap or swipe reported while touch stays active")

endmodule
